FILE: hw/rtl/npz_pkg.sv
// Types and fixed widths shared by the neutrino pz solver.
// No dependencies; the top level neutrino_pz_solver refers to this package.
package npz_pkg;

  localparam int unsigned PzW    = 24;
  localparam int unsigned LptW   = 48;
  localparam int unsigned T2W    = 51;
  localparam int unsigned T2MW   = 50;
  localparam int unsigned AW     = 74;
  localparam int unsigned TsqW   = 100;
  localparam int unsigned ProdW  = 96;
  localparam int unsigned RootW  = 74;
  localparam int unsigned RadW   = 148;
  localparam int unsigned SumW   = 77;
  localparam int unsigned MagW   = 76;
  localparam int unsigned DenW   = 49;

  localparam logic [31:0] WMassSqRst = 32'd1654208;
  localparam logic [1:0]  RootsNone  = 2'd0;
  localparam logic [1:0]  RootsTwo   = 2'd2;

  typedef struct packed {
    logic signed [23:0] lep_px;
    logic signed [23:0] lep_py;
    logic signed [23:0] lep_pz;
    logic signed [23:0] nu_px;
    logic signed [23:0] nu_py;
  } npz_in_t;

  typedef struct packed {
    logic [1:0]         root_count;
    logic signed [23:0] pz_low;
    logic signed [23:0] pz_high;
    logic               pt_zero_error;
  } npz_out_t;

  typedef struct packed {
    logic [LptW-1:0] e2;
    logic [LptW-1:0] lpt2;
  } m1_side_t;

  typedef struct packed {
    logic [AW-1:0]   a_mag;
    logic            a_neg;
    logic [LptW-1:0] lpt2;
    logic            ptz;
    logic            dneg;
  } m4_side_t;

  typedef struct packed {
    logic ptz;
    logic dneg;
  } div_side_t;

endpackage

FILE: hw/rtl/npz_mul.sv
// Pipelined unsigned multiplier: a row of cells, each adding one digit's
// partial product. Depends on nothing; side data travels with each product.
module npz_mul #(
  parameter int unsigned WA = 48,
  parameter int unsigned WB = 48,
  parameter int unsigned DW = 24,
  parameter int unsigned SW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [WA-1:0]      a_i,
  input  logic [WB-1:0]      b_i,
  input  logic [SW-1:0]      side_i,
  output logic               valid_o,
  output logic [WA+WB-1:0]   p_o,
  output logic [SW-1:0]      side_o
);

  localparam int unsigned ND = (WB + DW - 1) / DW;
  localparam int unsigned BW = ND * DW;
  localparam int unsigned PW = WA + WB;

  logic          v_q    [0:ND];
  logic [WA-1:0] a_q    [0:ND];
  logic [BW-1:0] b_q    [0:ND];
  logic [PW-1:0] acc_q  [0:ND];
  logic [SW-1:0] side_q [0:ND];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q[0]    <= a_i;
      b_q[0]    <= BW'(b_i);
      acc_q[0]  <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < ND; k++) begin : g_cell
    logic [WA+DW-1:0] pp;
    assign pp = a_q[k] * b_q[k][k*DW +: DW];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[k+1]    <= a_q[k];
        b_q[k+1]    <= b_q[k];
        acc_q[k+1]  <= acc_q[k] + (PW'(pp) << (k * DW));
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = v_q[ND];
  assign p_o     = acc_q[ND];
  assign side_o  = side_q[ND];

endmodule

FILE: hw/rtl/npz_sqrt.sv
// Integer square root, one result bit per cell, floor of the true root.
// Depends on nothing; side data travels with each radicand.
module npz_sqrt #(
  parameter int unsigned RW = 74,
  parameter int unsigned SW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*RW-1:0]   rad_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [RW-1:0]     root_o,
  output logic [SW-1:0]     side_o
);

  localparam int unsigned NW = 2 * RW;
  localparam int unsigned TW = NW + 1;

  logic          v_q    [0:RW];
  logic [NW-1:0] rem_q  [0:RW];
  logic [RW-1:0] root_q [0:RW];
  logic [SW-1:0] side_q [0:RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rad_i;
      root_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_cell
    localparam int unsigned B = RW - 1 - k;
    logic [TW-1:0] trial;
    logic          ge;
    assign trial = (TW'(root_q[k]) << (B + 1)) + (TW'(1) << (2 * B));
    assign ge    = TW'(rem_q[k]) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? rem_q[k] - trial[NW-1:0] : rem_q[k];
        root_q[k+1] <= ge ? root_q[k] | (RW'(1) << B) : root_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = v_q[RW];
  assign root_o  = root_q[RW];
  assign side_o  = side_q[RW];

endmodule

FILE: hw/rtl/npz_div.sv
// Signed floor division of a sign-magnitude value by a positive divisor,
// saturated to QW bits; a front stage flags overflow, then one cell per bit.
module npz_div #(
  parameter int unsigned MW = 76,
  parameter int unsigned DW = 49,
  parameter int unsigned QW = 24,
  parameter int unsigned SW = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic                 neg_i,
  input  logic [MW-1:0]        mag_i,
  input  logic [DW-1:0]        den_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic signed [QW-1:0] quot_o,
  output logic [SW-1:0]        side_o
);

  localparam int unsigned XW = (MW > DW + QW) ? MW : DW + QW;

  logic          v_q    [0:QW];
  logic          neg_q  [0:QW];
  logic          sat_q  [0:QW];
  logic [MW-1:0] rem_q  [0:QW];
  logic [QW-1:0] q_q    [0:QW];
  logic [DW-1:0] den_q  [0:QW];
  logic [SW-1:0] side_q [0:QW];

  logic [XW-1:0] lim;
  logic          sat_d;
  assign lim   = XW'(den_i) << (QW - 1);
  assign sat_d = neg_i ? (XW'(mag_i) > lim) : (XW'(mag_i) >= lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0]  <= neg_i;
      sat_q[0]  <= sat_d;
      rem_q[0]  <= mag_i;
      q_q[0]    <= '0;
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_cell
    localparam int unsigned B = QW - 1 - k;
    logic [XW-1:0] sh;
    logic          ge;
    assign sh = XW'(den_q[k]) << B;
    assign ge = XW'(rem_q[k]) >= sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[k+1]  <= neg_q[k];
        sat_q[k+1]  <= sat_q[k];
        rem_q[k+1]  <= ge ? rem_q[k] - sh[MW-1:0] : rem_q[k];
        q_q[k+1]    <= ge ? q_q[k] | (QW'(1) << B) : q_q[k];
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  logic          rnz;
  logic [QW:0]   qx;
  logic [QW:0]   qn;
  logic [QW-1:0] res_d;
  logic          out_v_q;
  logic [QW-1:0] res_q;
  logic [SW-1:0] out_side_q;

  assign rnz = rem_q[QW] != '0;
  assign qx  = {1'b0, q_q[QW]} + (QW+1)'(rnz);
  assign qn  = (QW+1)'(0) - qx;

  always_comb begin
    if (sat_q[QW]) begin
      res_d = neg_q[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else if (neg_q[QW]) begin
      res_d = qn[QW-1:0];
    end else begin
      res_d = q_q[QW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q      <= res_d;
      out_side_q <= side_q[QW];
    end
  end

  assign valid_o = out_v_q;
  assign quot_o  = $signed(res_q);
  assign side_o  = out_side_q;

endmodule

FILE: hw/rtl/neutrino_pz_solver.sv
// Top level of the neutrino pz solver: W-mass constraint quadratic per event.
// Depends on npz_pkg, npz_mul, npz_sqrt and npz_div.
//
// Input channel in_valid_i/in_ready_o carries one event (lepton px, py, pz and
// neutrino px, py); output channel out_valid_o/out_ready_i carries one result
// per event: root count (0 or 2), both roots in ascending order saturated to
// 24 bits, and the zero lepton pt flag.
// Configuration channel cfg_valid_i/cfg_ready_o writes w_mass_sq; it is always
// ready and must only be used while no event is in flight.
// Throughput: one event per cycle, sustained while the receiver does not stall.
// Behind the input register an event passes through the product stages, the
// first multipliers, the discriminant register, the radicand multiplier, the
// square root cells, the root sums register, the divider cells and the output
// register.
// Reset clears every valid bit and loads w_mass_sq with its default.
// When the receiver stalls, the whole chain holds; the input register still
// takes an event while it is empty.
module neutrino_pz_solver (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  npz_pkg::npz_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output npz_pkg::npz_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [31:0]       cfg_data_i
);

  logic [31:0] w_mass_sq_q;
  logic        adv;
  logic        out_valid_q;
  npz_pkg::npz_out_t out_q;

  assign adv         = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_mass_sq_q <= npz_pkg::WMassSqRst;
    end else if (cfg_valid_i) begin
      w_mass_sq_q <= cfg_data_i;
    end
  end

  // Input register
  logic             v0_q;
  npz_pkg::npz_in_t in_q;
  assign in_ready_o = adv || !v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (in_ready_o) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Squares and cross products
  logic signed [47:0] sq_lx, sq_ly, sq_lz, sq_nx, sq_ny, pxn_d, pyn_d;
  assign sq_lx = in_q.lep_px * in_q.lep_px;
  assign sq_ly = in_q.lep_py * in_q.lep_py;
  assign sq_lz = in_q.lep_pz * in_q.lep_pz;
  assign sq_nx = in_q.nu_px * in_q.nu_px;
  assign sq_ny = in_q.nu_py * in_q.nu_py;
  assign pxn_d = in_q.lep_px * in_q.nu_px;
  assign pyn_d = in_q.lep_py * in_q.nu_py;

  logic               v1_q;
  logic [46:0]        lx2_q, ly2_q, lz2_q, nx2_q, ny2_q;
  logic signed [47:0] pxn_q, pyn_q;
  logic signed [23:0] lz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lx2_q <= sq_lx[46:0];
      ly2_q <= sq_ly[46:0];
      lz2_q <= sq_lz[46:0];
      nx2_q <= sq_nx[46:0];
      ny2_q <= sq_ny[46:0];
      pxn_q <= pxn_d;
      pyn_q <= pyn_d;
      lz1_q <= in_q.lep_pz;
    end
  end

  // Sums, T2 and signs
  logic [npz_pkg::LptW-1:0]   lpt2_d, e2_d, npt2_d;
  logic signed [npz_pkg::T2W-1:0] pxy, t2, t2_abs;
  logic signed [23:0]         lz_abs;
  logic                       aneg_d, ptz_d;

  assign lpt2_d = npz_pkg::LptW'(lx2_q) + npz_pkg::LptW'(ly2_q);
  assign e2_d   = lpt2_d + npz_pkg::LptW'(lz2_q);
  assign npt2_d = npz_pkg::LptW'(nx2_q) + npz_pkg::LptW'(ny2_q);
  assign pxy    = npz_pkg::T2W'(pxn_q) + npz_pkg::T2W'(pyn_q);
  assign t2     = npz_pkg::T2W'($signed({1'b0, w_mass_sq_q})) + (pxy <<< 1);
  assign t2_abs = t2[npz_pkg::T2W-1] ? -t2 : t2;
  assign lz_abs = lz1_q[23] ? -lz1_q : lz1_q;
  assign aneg_d = (lz1_q[23] != t2[npz_pkg::T2W-1]) && (lz1_q != '0) && (t2 != '0);
  assign ptz_d  = lpt2_d == '0;

  logic                      v2_q;
  logic [npz_pkg::LptW-1:0]  lpt2_q, e2_q, npt2_q;
  logic [npz_pkg::T2MW-1:0]  t2m_q;
  logic [23:0]               lzm_q;
  logic                      aneg_q, ptz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lpt2_q <= lpt2_d;
      e2_q   <= e2_d;
      npt2_q <= npt2_d;
      t2m_q  <= t2_abs[npz_pkg::T2MW-1:0];
      lzm_q  <= lz_abs;
      aneg_q <= aneg_d;
      ptz_q  <= ptz_d;
    end
  end

  // T2 squared, lpt2 * npt2 and lz * T2
  npz_pkg::m1_side_t m1_si, m1_so;
  logic                      m1_v, m2_v, m3_v;
  logic [npz_pkg::TsqW-1:0]  tsq;
  logic [npz_pkg::ProdW-1:0] prod;
  logic [npz_pkg::AW-1:0]    amag;
  logic                      m2_so, m3_so;

  assign m1_si = '{e2: e2_q, lpt2: lpt2_q};

  npz_mul #(.WA(npz_pkg::T2MW), .WB(npz_pkg::T2MW), .DW(25), .SW($bits(m1_si))) u_mul_tsq (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v2_q), .a_i(t2m_q), .b_i(t2m_q),
    .side_i(m1_si), .valid_o(m1_v), .p_o(tsq), .side_o(m1_so)
  );

  npz_mul #(.WA(npz_pkg::LptW), .WB(npz_pkg::LptW), .DW(24), .SW(1)) u_mul_pt (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v2_q), .a_i(lpt2_q), .b_i(npt2_q),
    .side_i(ptz_q), .valid_o(m2_v), .p_o(prod), .side_o(m2_so)
  );

  npz_mul #(.WA(24), .WB(npz_pkg::T2MW), .DW(25), .SW(1)) u_mul_a (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v2_q), .a_i(lzm_q), .b_i(t2m_q),
    .side_i(aneg_q), .valid_o(m3_v), .p_o(amag), .side_o(m3_so)
  );

  // Discriminant
  logic [npz_pkg::TsqW-1:0] four_d, dsc_d;
  logic                     dneg_d;
  assign four_d = npz_pkg::TsqW'({prod, 2'b00});
  assign dneg_d = four_d > tsq;
  assign dsc_d  = tsq - four_d;

  logic                      v3_q, aneg3_q, ptz3_q, dneg_q;
  logic [npz_pkg::TsqW-1:0]  dsc_q;
  logic [npz_pkg::LptW-1:0]  e2b_q, lpt2b_q;
  logic [npz_pkg::AW-1:0]    amag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= m1_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dsc_q   <= dsc_d;
      dneg_q  <= dneg_d;
      e2b_q   <= m1_so.e2;
      lpt2b_q <= m1_so.lpt2;
      amag_q  <= amag;
      aneg3_q <= m3_so;
      ptz3_q  <= m2_so;
    end
  end

  // Radicand and its root
  npz_pkg::m4_side_t m4_si, m4_so, sq_so;
  logic                     m4_v, sq_v;
  logic [npz_pkg::RadW-1:0] rad;
  logic [npz_pkg::RootW-1:0] root;

  assign m4_si = '{a_mag: amag_q, a_neg: aneg3_q, lpt2: lpt2b_q, ptz: ptz3_q, dneg: dneg_q};

  npz_mul #(.WA(npz_pkg::LptW), .WB(npz_pkg::TsqW), .DW(25), .SW($bits(m4_si))) u_mul_rad (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v3_q), .a_i(e2b_q), .b_i(dsc_q),
    .side_i(m4_si), .valid_o(m4_v), .p_o(rad), .side_o(m4_so)
  );

  npz_sqrt #(.RW(npz_pkg::RootW), .SW($bits(m4_si))) u_sqrt (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(m4_v), .rad_i(rad),
    .side_i(m4_so), .valid_o(sq_v), .root_o(root), .side_o(sq_so)
  );

  // Numerators A - S and A + S
  logic signed [npz_pkg::SumW-1:0] as_d, lo_d, hi_d, lo_abs, hi_abs;
  assign as_d   = sq_so.a_neg ? -npz_pkg::SumW'(sq_so.a_mag) : npz_pkg::SumW'(sq_so.a_mag);
  assign lo_d   = as_d - npz_pkg::SumW'(root);
  assign hi_d   = as_d + npz_pkg::SumW'(root);
  assign lo_abs = lo_d[npz_pkg::SumW-1] ? -lo_d : lo_d;
  assign hi_abs = hi_d[npz_pkg::SumW-1] ? -hi_d : hi_d;

  logic                      v4_q, lo_neg_q, hi_neg_q;
  logic [npz_pkg::MagW-1:0]  lo_mag_q, hi_mag_q;
  logic [npz_pkg::DenW-1:0]  den_q;
  npz_pkg::div_side_t        side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lo_neg_q <= lo_d[npz_pkg::SumW-1];
      hi_neg_q <= hi_d[npz_pkg::SumW-1];
      lo_mag_q <= lo_abs[npz_pkg::MagW-1:0];
      hi_mag_q <= hi_abs[npz_pkg::MagW-1:0];
      den_q    <= {sq_so.lpt2, 1'b0};
      side4_q  <= '{ptz: sq_so.ptz, dneg: sq_so.dneg};
    end
  end

  // Divisions by 2 * lpt2
  logic                           dl_v, dh_v;
  logic signed [npz_pkg::PzW-1:0] q_lo, q_hi;
  npz_pkg::div_side_t             dl_so, dh_so;

  npz_div #(.MW(npz_pkg::MagW), .DW(npz_pkg::DenW), .QW(npz_pkg::PzW),
            .SW($bits(side4_q))) u_div_lo (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v4_q), .neg_i(lo_neg_q), .mag_i(lo_mag_q),
    .den_i(den_q), .side_i(side4_q), .valid_o(dl_v), .quot_o(q_lo), .side_o(dl_so)
  );

  npz_div #(.MW(npz_pkg::MagW), .DW(npz_pkg::DenW), .QW(npz_pkg::PzW),
            .SW($bits(side4_q))) u_div_hi (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v4_q), .neg_i(hi_neg_q), .mag_i(hi_mag_q),
    .den_i(den_q), .side_i(side4_q), .valid_o(dh_v), .quot_o(q_hi), .side_o(dh_so)
  );

  // Output register
  npz_pkg::npz_out_t out_d;
  logic              no_root;
  assign no_root = dl_so.ptz || dl_so.dneg;

  always_comb begin
    out_d.root_count    = no_root ? npz_pkg::RootsNone : npz_pkg::RootsTwo;
    out_d.pz_low        = no_root ? '0 : q_lo;
    out_d.pz_high       = no_root ? '0 : q_hi;
    out_d.pt_zero_error = dl_so.ptz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dl_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_mul_valid_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m1_v == m2_v) && (m1_v == m3_v))
    else $error("multiplier valids out of step");

  a_div_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dl_v == dh_v) && (!dl_v || (dl_so == dh_so)))
    else $error("divider lanes out of step");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && v0_q))
    else $error("input held off without an output stall");

  a_roots_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.root_count == npz_pkg::RootsTwo) |->
      ($signed(out_data_o.pz_low) <= $signed(out_data_o.pz_high)))
    else $error("roots not in ascending order");

  a_error_no_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.pt_zero_error) |->
      (out_data_o.root_count == npz_pkg::RootsNone))
    else $error("roots reported with zero lepton pt");

endmodule
